// ===== hw/rtl/imuhm_pkg.sv =====
// imuhm_pkg: shared types and constants of the IMU health monitor.
// Holds the input and result word structs, the sequencer states, register indexes
// and status codes. Depends on nothing.
`default_nettype none

package imuhm_pkg;

    // input word: one sample or one check request
    typedef struct packed {
        logic               cmd;
        logic [31:0]        time_us;
        logic               rot_rate_bad;
        logic               lin_acc_bad;
        logic signed [15:0] lin_acc_x;
        logic signed [15:0] lin_acc_y;
        logic signed [15:0] lin_acc_z;
    } t_in_word;

    // result word of a check
    typedef struct packed {
        logic [1:0]  health_level;
        logic [3:0]  health_cause;
        logic [8:0]  window_samples;
        logic [20:0] window_span_us;
        logic [31:0] since_last_us;
        logic [31:0] acc_mag_sq;
    } t_out_word;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SQ_Z,
        ST_PRUNE,
        ST_MUL_ER,
        ST_MUL_WR,
        ST_MUL_ES,
        ST_MUL_WS,
        ST_MUL_EL,
        ST_MUL_WL,
        ST_MUL_LHS,
        ST_DECIDE
    } t_state;

    // commands
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_CHECK  = 1'b1;

    // configuration register indexes
    localparam logic [2:0] CFG_EXP_RATE  = 3'd0;
    localparam logic [2:0] CFG_WARN_RAT  = 3'd1;
    localparam logic [2:0] CFG_ERR_RAT   = 3'd2;
    localparam logic [2:0] CFG_STALE     = 3'd3;
    localparam logic [2:0] CFG_ACC_WARN  = 3'd4;
    localparam logic [2:0] CFG_ACC_ERR   = 3'd5;

    // register reset values
    localparam logic [15:0] RST_EXP_RATE = 16'd100;
    localparam logic [8:0]  RST_WARN_RAT = 9'd179;
    localparam logic [8:0]  RST_ERR_RAT  = 9'd102;
    localparam logic [31:0] RST_STALE    = 32'd500000;
    localparam logic [14:0] RST_ACC_WARN = 15'd7680;
    localparam logic [14:0] RST_ACC_ERR  = 15'd12800;

    // health levels
    localparam logic [1:0] LVL_OK    = 2'd0;
    localparam logic [1:0] LVL_WARN  = 2'd1;
    localparam logic [1:0] LVL_ERROR = 2'd2;
    localparam logic [1:0] LVL_STALE = 2'd3;

    // health causes
    localparam logic [3:0] CAUSE_NONE      = 4'd0;
    localparam logic [3:0] CAUSE_NEVER     = 4'd1;
    localparam logic [3:0] CAUSE_TIMEOUT   = 4'd2;
    localparam logic [3:0] CAUSE_GYRO_BAD  = 4'd3;
    localparam logic [3:0] CAUSE_ACC_BAD   = 4'd4;
    localparam logic [3:0] CAUSE_RATE_ERR  = 4'd5;
    localparam logic [3:0] CAUSE_RATE_WARN = 4'd6;
    localparam logic [3:0] CAUSE_ACC_ERR   = 4'd7;
    localparam logic [3:0] CAUSE_ACC_WARN  = 4'd8;

    // microseconds per second times the Q1.8 scale
    localparam logic [31:0] RATE_SCALE = 32'd256000000;
    localparam int          RATE_SCALE_W = 28;

    // widths of rate-check products
    localparam int RATIO_PROD_W = 25;   // ratio(9) x rate(16)
    localparam int RHS_W        = 57;   // ratio product x span(32)
    localparam int SQ_LIM_W     = 30;   // limit(15) squared

endpackage

`default_nettype wire

// ===== hw/rtl/imu_health_monitor.sv =====
// imu_health_monitor: IMU health monitor top level (ring memory, sequencer, checks).
// Depends on imuhm_pkg.
`default_nettype none

// A sample word (cmd 0) stores its arrival time in a ring memory and records the
// validity flags and squared accel magnitude; a check word (cmd 1) returns one
// result word with health level and cause. One word is in work at a time. A sample
// first builds its squared magnitude through one shared 32x32 multiplier in three
// steps, then trims the window, reading the oldest ring entry once per cycle through
// the memory's single registered read port and dropping each arrival time outside
// the window. A check makes seven passes through the same multiplier to build the
// rate and magnitude thresholds, then a decide state loads the output register once
// that register is free. The result waits in that register while the next input
// word is taken. No clearing pass is needed after reset.
module imu_health_monitor #(
    parameter int RING_DEPTH = 256,
    parameter int WINDOW_US  = 2000000
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // input channel
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire imuhm_pkg::t_in_word  i_in_word,
    // result channel
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output imuhm_pkg::t_out_word      o_out_word,
    // configuration
    input  wire logic                 i_cfg_we,
    input  wire logic [2:0]           i_cfg_index,
    input  wire logic [31:0]          i_cfg_data
);

    localparam int IDX_W = $clog2(RING_DEPTH);
    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam int LHS_W = CNT_W + imuhm_pkg::RATE_SCALE_W;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(RING_DEPTH);
    localparam logic [CNT_W:0]   DEPTH_X = (CNT_W+1)'(RING_DEPTH);
    localparam logic [31:0]      WIN_C   = 32'(WINDOW_US);

    // configuration registers
    logic [15:0] r_exp_rate;
    logic [8:0]  r_warn_rat;
    logic [8:0]  r_err_rat;
    logic [31:0] r_stale;
    logic [14:0] r_acc_warn;
    logic [14:0] r_acc_err;

    // control state
    imuhm_pkg::t_state r_state, n_state;
    logic [IDX_W-1:0]  r_head, n_head;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_seen, n_seen;
    logic              r_rot_bad, n_rot_bad;
    logic              r_acc_bad, n_acc_bad;
    logic [31:0]       r_last_time, n_last_time;
    logic [31:0]       r_mag, n_mag;
    logic              r_out_valid, n_out_valid;

    // working registers
    logic [31:0]                        r_oldest, n_oldest;
    logic [16:0]                        r_abs_x, n_abs_x;
    logic [16:0]                        r_abs_y, n_abs_y;
    logic [16:0]                        r_abs_z, n_abs_z;
    logic [31:0]                        r_since, n_since;
    logic [31:0]                        r_span, n_span;
    logic                               r_rate_ok, n_rate_ok;
    logic [imuhm_pkg::RATIO_PROD_W-1:0] r_p_err, n_p_err;
    logic [imuhm_pkg::RATIO_PROD_W-1:0] r_p_warn, n_p_warn;
    logic [imuhm_pkg::RHS_W-1:0]        r_rhs_err, n_rhs_err;
    logic [imuhm_pkg::RHS_W-1:0]        r_rhs_warn, n_rhs_warn;
    logic [imuhm_pkg::SQ_LIM_W-1:0]     r_esq, n_esq;
    logic [imuhm_pkg::SQ_LIM_W-1:0]     r_wsq, n_wsq;
    logic [LHS_W-1:0]                   r_lhs, n_lhs;
    imuhm_pkg::t_out_word               r_out, n_out;

    // ring memory
    logic [31:0]      r_ring [RING_DEPTH];
    logic [31:0]      r_rd_data;
    logic [IDX_W-1:0] rd_addr;
    logic             ring_we;
    logic [CNT_W:0]   old_sum;

    // misc combinational
    logic             in_acc;
    logic             drop;
    logic             out_load;
    logic [CNT_W-1:0] cnt_base;
    logic [IDX_W-1:0] head_inc;
    logic [31:0]      span_now;
    logic [16:0]      ext_x, ext_y, ext_z;
    logic [31:0]      mul_a, mul_b;
    logic [63:0]      mul_p;
    logic [63:0]      lhs_e, erhs_e, wrhs_e;
    logic [1:0]       dec_lvl;
    logic [3:0]       dec_cause;

    assign in_acc     = i_in_valid && (r_state == imuhm_pkg::ST_IDLE);
    assign o_in_stall = (r_state != imuhm_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // oldest-time drop test during trimming; newest time is the last arrival
    assign drop = (r_count != '0) && ((r_last_time - r_rd_data) > WIN_C);

    assign out_load = (r_state == imuhm_pkg::ST_DECIDE) && (!r_out_valid || !i_out_stall);

    // ring pointer arithmetic
    assign head_inc = (r_head == IDX_W'(RING_DEPTH - 1)) ? '0 : r_head + IDX_W'(1);
    assign cnt_base = (r_count >= DEPTH_C) ? DEPTH_C - CNT_W'(1) : r_count;

    // read address follows the oldest entry of the next count
    always_comb begin
        old_sum = (CNT_W+1)'(n_head) + DEPTH_X - (CNT_W+1)'(n_count);
        if (old_sum >= DEPTH_X) begin
            old_sum = old_sum - DEPTH_X;
        end
        rd_addr = old_sum[IDX_W-1:0];
    end

    assign span_now = (r_count >= CNT_W'(2)) ? r_last_time - r_oldest : '0;

    // sign-extended accel components
    assign ext_x = {i_in_word.lin_acc_x[15], i_in_word.lin_acc_x};
    assign ext_y = {i_in_word.lin_acc_y[15], i_in_word.lin_acc_y};
    assign ext_z = {i_in_word.lin_acc_z[15], i_in_word.lin_acc_z};

    // shared multiplier operand select
    always_comb begin
        unique case (r_state)
            imuhm_pkg::ST_SQ_X: begin
                mul_a = 32'(r_abs_x);
                mul_b = 32'(r_abs_x);
            end
            imuhm_pkg::ST_SQ_Y: begin
                mul_a = 32'(r_abs_y);
                mul_b = 32'(r_abs_y);
            end
            imuhm_pkg::ST_SQ_Z: begin
                mul_a = 32'(r_abs_z);
                mul_b = 32'(r_abs_z);
            end
            imuhm_pkg::ST_MUL_ER: begin
                mul_a = 32'(r_err_rat);
                mul_b = 32'(r_exp_rate);
            end
            imuhm_pkg::ST_MUL_WR: begin
                mul_a = 32'(r_warn_rat);
                mul_b = 32'(r_exp_rate);
            end
            imuhm_pkg::ST_MUL_ES: begin
                mul_a = 32'(r_p_err);
                mul_b = r_span;
            end
            imuhm_pkg::ST_MUL_WS: begin
                mul_a = 32'(r_p_warn);
                mul_b = r_span;
            end
            imuhm_pkg::ST_MUL_EL: begin
                mul_a = 32'(r_acc_err);
                mul_b = 32'(r_acc_err);
            end
            imuhm_pkg::ST_MUL_WL: begin
                mul_a = 32'(r_acc_warn);
                mul_b = 32'(r_acc_warn);
            end
            imuhm_pkg::ST_MUL_LHS: begin
                mul_a = 32'(r_count - CNT_W'(1));
                mul_b = imuhm_pkg::RATE_SCALE;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            imuhm_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_state = (i_in_word.cmd == imuhm_pkg::CMD_CHECK) ?
                              imuhm_pkg::ST_MUL_ER : imuhm_pkg::ST_SQ_X;
                end
            end
            imuhm_pkg::ST_SQ_X:    n_state = imuhm_pkg::ST_SQ_Y;
            imuhm_pkg::ST_SQ_Y:    n_state = imuhm_pkg::ST_SQ_Z;
            imuhm_pkg::ST_SQ_Z:    n_state = imuhm_pkg::ST_PRUNE;
            imuhm_pkg::ST_PRUNE: begin
                if (!drop) begin
                    n_state = imuhm_pkg::ST_IDLE;
                end
            end
            imuhm_pkg::ST_MUL_ER:  n_state = imuhm_pkg::ST_MUL_WR;
            imuhm_pkg::ST_MUL_WR:  n_state = imuhm_pkg::ST_MUL_ES;
            imuhm_pkg::ST_MUL_ES:  n_state = imuhm_pkg::ST_MUL_WS;
            imuhm_pkg::ST_MUL_WS:  n_state = imuhm_pkg::ST_MUL_EL;
            imuhm_pkg::ST_MUL_EL:  n_state = imuhm_pkg::ST_MUL_WL;
            imuhm_pkg::ST_MUL_WL:  n_state = imuhm_pkg::ST_MUL_LHS;
            imuhm_pkg::ST_MUL_LHS: n_state = imuhm_pkg::ST_DECIDE;
            imuhm_pkg::ST_DECIDE: begin
                if (out_load) begin
                    n_state = imuhm_pkg::ST_IDLE;
                end
            end
            default: n_state = imuhm_pkg::ST_IDLE;
        endcase
    end

    // health decision from registered thresholds
    always_comb begin
        lhs_e  = r_rate_ok ? 64'(r_lhs) : '0;
        erhs_e = r_rate_ok ? 64'(r_rhs_err) : 64'(r_err_rat);
        wrhs_e = r_rate_ok ? 64'(r_rhs_warn) : 64'(r_warn_rat);
        dec_lvl   = imuhm_pkg::LVL_OK;
        dec_cause = imuhm_pkg::CAUSE_NONE;
        if (!r_seen) begin
            dec_lvl   = imuhm_pkg::LVL_STALE;
            dec_cause = imuhm_pkg::CAUSE_NEVER;
        end else if (r_since > r_stale) begin
            dec_lvl   = imuhm_pkg::LVL_STALE;
            dec_cause = imuhm_pkg::CAUSE_TIMEOUT;
        end else begin
            // bad vectors
            if (r_rot_bad) begin
                dec_lvl   = imuhm_pkg::LVL_ERROR;
                dec_cause = imuhm_pkg::CAUSE_GYRO_BAD;
            end else if (r_acc_bad) begin
                dec_lvl   = imuhm_pkg::LVL_ERROR;
                dec_cause = imuhm_pkg::CAUSE_ACC_BAD;
            end
            // sample rate
            if (dec_lvl != imuhm_pkg::LVL_ERROR && r_exp_rate != '0) begin
                if (lhs_e < erhs_e) begin
                    dec_lvl   = imuhm_pkg::LVL_ERROR;
                    dec_cause = imuhm_pkg::CAUSE_RATE_ERR;
                end else if (lhs_e < wrhs_e && dec_lvl == imuhm_pkg::LVL_OK) begin
                    dec_lvl   = imuhm_pkg::LVL_WARN;
                    dec_cause = imuhm_pkg::CAUSE_RATE_WARN;
                end
            end
            // accel magnitude
            if (dec_lvl != imuhm_pkg::LVL_ERROR) begin
                if (r_acc_err != '0 && r_mag > 32'(r_esq)) begin
                    dec_lvl   = imuhm_pkg::LVL_ERROR;
                    dec_cause = imuhm_pkg::CAUSE_ACC_ERR;
                end else if (r_acc_warn != '0 && r_mag > 32'(r_wsq) &&
                             dec_lvl == imuhm_pkg::LVL_OK) begin
                    dec_lvl   = imuhm_pkg::LVL_WARN;
                    dec_cause = imuhm_pkg::CAUSE_ACC_WARN;
                end
            end
        end
    end

    // datapath next values
    always_comb begin
        n_head      = r_head;
        n_count     = r_count;
        n_seen      = r_seen;
        n_rot_bad   = r_rot_bad;
        n_acc_bad   = r_acc_bad;
        n_last_time = r_last_time;
        n_mag       = r_mag;
        n_oldest    = r_oldest;
        n_abs_x     = r_abs_x;
        n_abs_y     = r_abs_y;
        n_abs_z     = r_abs_z;
        n_since     = r_since;
        n_span      = r_span;
        n_rate_ok   = r_rate_ok;
        n_p_err     = r_p_err;
        n_p_warn    = r_p_warn;
        n_rhs_err   = r_rhs_err;
        n_rhs_warn  = r_rhs_warn;
        n_esq       = r_esq;
        n_wsq       = r_wsq;
        n_lhs       = r_lhs;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        ring_we     = 1'b0;

        unique case (r_state)
            imuhm_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (i_in_word.cmd == imuhm_pkg::CMD_SAMPLE) begin
                        // store arrival, drop the oldest of a full ring
                        ring_we     = 1'b1;
                        n_head      = head_inc;
                        n_count     = cnt_base + CNT_W'(1);
                        n_seen      = 1'b1;
                        n_rot_bad   = i_in_word.rot_rate_bad;
                        n_acc_bad   = i_in_word.lin_acc_bad;
                        n_last_time = i_in_word.time_us;
                        n_mag       = '0;
                        n_abs_x     = ext_x[16] ? (~ext_x + 17'd1) : ext_x;
                        n_abs_y     = ext_y[16] ? (~ext_y + 17'd1) : ext_y;
                        n_abs_z     = ext_z[16] ? (~ext_z + 17'd1) : ext_z;
                    end else begin
                        n_since   = i_in_word.time_us - r_last_time;
                        n_span    = span_now;
                        n_rate_ok = (r_count >= CNT_W'(2)) && (span_now != '0);
                    end
                end
            end
            imuhm_pkg::ST_SQ_X, imuhm_pkg::ST_SQ_Y, imuhm_pkg::ST_SQ_Z: begin
                n_mag = r_mag + mul_p[31:0];
            end
            imuhm_pkg::ST_PRUNE: begin
                if (drop) begin
                    n_count = r_count - CNT_W'(1);
                end else begin
                    n_oldest = r_rd_data;
                end
            end
            imuhm_pkg::ST_MUL_ER:  n_p_err    = mul_p[imuhm_pkg::RATIO_PROD_W-1:0];
            imuhm_pkg::ST_MUL_WR:  n_p_warn   = mul_p[imuhm_pkg::RATIO_PROD_W-1:0];
            imuhm_pkg::ST_MUL_ES:  n_rhs_err  = mul_p[imuhm_pkg::RHS_W-1:0];
            imuhm_pkg::ST_MUL_WS:  n_rhs_warn = mul_p[imuhm_pkg::RHS_W-1:0];
            imuhm_pkg::ST_MUL_EL:  n_esq      = mul_p[imuhm_pkg::SQ_LIM_W-1:0];
            imuhm_pkg::ST_MUL_WL:  n_wsq      = mul_p[imuhm_pkg::SQ_LIM_W-1:0];
            imuhm_pkg::ST_MUL_LHS: n_lhs      = mul_p[LHS_W-1:0];
            imuhm_pkg::ST_DECIDE: begin
                if (out_load) begin
                    n_out.health_level   = dec_lvl;
                    n_out.health_cause   = dec_cause;
                    n_out.window_samples = 9'(r_count);
                    n_out.window_span_us = r_span[20:0];
                    n_out.since_last_us  = r_since;
                    n_out.acc_mag_sq     = r_mag;
                end
            end
            default: ;
        endcase

        // output register handshake
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    // ring memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            r_ring[r_head] <= i_in_word.time_us;
        end
        r_rd_data <= r_ring[rd_addr];
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_rate <= imuhm_pkg::RST_EXP_RATE;
            r_warn_rat <= imuhm_pkg::RST_WARN_RAT;
            r_err_rat  <= imuhm_pkg::RST_ERR_RAT;
            r_stale    <= imuhm_pkg::RST_STALE;
            r_acc_warn <= imuhm_pkg::RST_ACC_WARN;
            r_acc_err  <= imuhm_pkg::RST_ACC_ERR;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                imuhm_pkg::CFG_EXP_RATE: r_exp_rate <= i_cfg_data[15:0];
                imuhm_pkg::CFG_WARN_RAT: r_warn_rat <= i_cfg_data[8:0];
                imuhm_pkg::CFG_ERR_RAT:  r_err_rat  <= i_cfg_data[8:0];
                imuhm_pkg::CFG_STALE:    r_stale    <= i_cfg_data;
                imuhm_pkg::CFG_ACC_WARN: r_acc_warn <= i_cfg_data[14:0];
                imuhm_pkg::CFG_ACC_ERR:  r_acc_err  <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // control state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= imuhm_pkg::ST_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_seen      <= 1'b0;
            r_rot_bad   <= 1'b0;
            r_acc_bad   <= 1'b0;
            r_last_time <= '0;
            r_mag       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_seen      <= n_seen;
            r_rot_bad   <= n_rot_bad;
            r_acc_bad   <= n_acc_bad;
            r_last_time <= n_last_time;
            r_mag       <= n_mag;
            r_out_valid <= n_out_valid;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_oldest   <= n_oldest;
        r_abs_x    <= n_abs_x;
        r_abs_y    <= n_abs_y;
        r_abs_z    <= n_abs_z;
        r_since    <= n_since;
        r_span     <= n_span;
        r_rate_ok  <= n_rate_ok;
        r_p_err    <= n_p_err;
        r_p_warn   <= n_p_warn;
        r_rhs_err  <= n_rhs_err;
        r_rhs_warn <= n_rhs_warn;
        r_esq      <= n_esq;
        r_wsq      <= n_wsq;
        r_lhs      <= n_lhs;
        r_out      <= n_out;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/imuhm_checker.sv =====
// imuhm_checker: port-level assertions for the IMU health monitor, and its bind.
// Depends on imuhm_pkg and imu_health_monitor.
`default_nettype none

module imuhm_checker (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 out_valid,
    input wire logic                 out_stall,
    input wire imuhm_pkg::t_out_word out_word
);

    // a stalled result word stays valid
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result word dropped while stalled");

    // a stalled result word keeps its value
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_word))
        else $error("result word changed while stalled");

    // stale level goes with a stale cause, and only then
    a_stale_cause: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_word.health_level == imuhm_pkg::LVL_STALE) ==
                       (out_word.health_cause == imuhm_pkg::CAUSE_NEVER ||
                        out_word.health_cause == imuhm_pkg::CAUSE_TIMEOUT)))
        else $error("stale level and cause disagree");

    // ok level carries no cause
    a_ok_cause: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_word.health_level == imuhm_pkg::LVL_OK) ==
                       (out_word.health_cause == imuhm_pkg::CAUSE_NONE)))
        else $error("ok level and cause disagree");

    // warn level only from a rate or accel warning
    a_warn_cause: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_word.health_level == imuhm_pkg::LVL_WARN) ==
                       (out_word.health_cause == imuhm_pkg::CAUSE_RATE_WARN ||
                        out_word.health_cause == imuhm_pkg::CAUSE_ACC_WARN)))
        else $error("warn level and cause disagree");

endmodule

bind imu_health_monitor imuhm_checker u_imuhm_checker (
    .clk       (i_clk),
    .rst_n     (i_rst_n),
    .out_valid (o_out_valid),
    .out_stall (i_out_stall),
    .out_word  (o_out_word)
);

`default_nettype wire

// ===== dv/imu_health_monitor_tb.sv =====
// imu_health_monitor_tb: self-checking testbench of the IMU health monitor.
// Directed word table, then random sample streams under six register settings.
// Depends on imuhm_pkg and imu_health_monitor.
`default_nettype none

module imu_health_monitor_tb;

    import imuhm_pkg::*;

    localparam int          RING_DEPTH    = 256;
    localparam logic [31:0] WINDOW_US     = 32'd2000000;
    localparam int          CYCLE_LIMIT   = 2000000;
    localparam int          SETTLE_CYCLES = 300;   // covers a full window trim
    localparam int          PHASE_WORDS   = 200;
    localparam int          MAX_SHOWN     = 10;

    // directed table row; typed rows carry their own expected word
    typedef struct {
        t_in_word  word;
        bit        typed;
        t_out_word want;
    } t_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    t_in_word   i_in_word;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_out_word  o_out_word;
    logic       i_cfg_we;
    logic [2:0] i_cfg_index;
    logic [31:0] i_cfg_data;

    // health model state and its copy of the registers
    logic [31:0] hm_times [RING_DEPTH];
    int          hm_head;
    int          hm_count;
    logic [31:0] hm_last_us;
    logic [31:0] hm_mag_sq;
    bit          hm_seen;
    bit          hm_rot_bad;
    bit          hm_acc_bad;
    logic [15:0] cf_rate;
    logic [8:0]  cf_warn_ratio;
    logic [8:0]  cf_err_ratio;
    logic [31:0] cf_stale;
    logic [14:0] cf_acc_warn;
    logic [14:0] cf_acc_err;

    t_out_word   pending_reports[$];
    t_row        script[$];
    t_out_word   want;
    t_out_word   got;
    logic [31:0] stream_now;
    int          idle_pct;
    int          stall_pct;
    int          bad_count;
    int          cycles;

    imu_health_monitor #(
        .RING_DEPTH (RING_DEPTH),
        .WINDOW_US  (WINDOW_US)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // run limit
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("imu_health_monitor_tb: done, errors");
            $finish;
        end
    end

    // result side back-pressure
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    function automatic int oldest_slot();
        return (hm_head + RING_DEPTH - hm_count) % RING_DEPTH;
    endfunction

    // update the model with one accepted word; a check queues its report
    task automatic predict_health(input t_in_word w);
        int          ax, ay, az;
        logic [31:0] sq_x, sq_y, sq_z;
        logic [31:0] since, span, esq, wsq;
        logic [63:0] lhs, err_rhs, warn_rhs;
        logic [1:0]  lvl;
        logic [3:0]  cause;
        t_out_word   r;
        if (w.cmd == CMD_SAMPLE) begin
            ax = $signed(w.lin_acc_x);
            ay = $signed(w.lin_acc_y);
            az = $signed(w.lin_acc_z);
            sq_x = ax * ax;
            sq_y = ay * ay;
            sq_z = az * az;
            hm_last_us = w.time_us;
            hm_seen    = 1'b1;
            hm_rot_bad = w.rot_rate_bad;
            hm_acc_bad = w.lin_acc_bad;
            hm_mag_sq  = sq_x + sq_y + sq_z;
            // full ring loses its oldest time first
            if (hm_count >= RING_DEPTH)
                hm_count = RING_DEPTH - 1;
            hm_times[hm_head] = w.time_us;
            hm_head  = (hm_head + 1) % RING_DEPTH;
            hm_count = hm_count + 1;
            // trim times older than the window
            while (hm_count > 0 && (w.time_us - hm_times[oldest_slot()]) > WINDOW_US)
                hm_count = hm_count - 1;
        end else begin
            since = w.time_us - hm_last_us;
            span  = '0;
            if (hm_count >= 2)
                span = hm_times[(hm_head + RING_DEPTH - 1) % RING_DEPTH]
                       - hm_times[oldest_slot()];
            lvl   = LVL_OK;
            cause = CAUSE_NONE;
            if (!hm_seen) begin
                lvl   = LVL_STALE;
                cause = CAUSE_NEVER;
            end else if (since > cf_stale) begin
                lvl   = LVL_STALE;
                cause = CAUSE_TIMEOUT;
            end else begin
                if (hm_rot_bad) begin
                    lvl   = LVL_ERROR;
                    cause = CAUSE_GYRO_BAD;
                end else if (hm_acc_bad) begin
                    lvl   = LVL_ERROR;
                    cause = CAUSE_ACC_BAD;
                end
                // rate ratio by cross multiplication
                if (lvl < LVL_ERROR && cf_rate != 16'd0) begin
                    if (hm_count >= 2 && span != 32'd0) begin
                        lhs      = hm_count - 1;
                        lhs      = lhs * RATE_SCALE;
                        err_rhs  = cf_err_ratio;
                        err_rhs  = err_rhs * cf_rate * span;
                        warn_rhs = cf_warn_ratio;
                        warn_rhs = warn_rhs * cf_rate * span;
                    end else begin
                        lhs      = '0;
                        err_rhs  = cf_err_ratio;
                        warn_rhs = cf_warn_ratio;
                    end
                    if (lhs < err_rhs) begin
                        lvl   = LVL_ERROR;
                        cause = CAUSE_RATE_ERR;
                    end else if (lhs < warn_rhs && lvl == LVL_OK) begin
                        lvl   = LVL_WARN;
                        cause = CAUSE_RATE_WARN;
                    end
                end
                // magnitude limits on squared values; zero limit is off
                if (lvl < LVL_ERROR) begin
                    esq = cf_acc_err * cf_acc_err;
                    wsq = cf_acc_warn * cf_acc_warn;
                    if (cf_acc_err != 15'd0 && hm_mag_sq > esq) begin
                        lvl   = LVL_ERROR;
                        cause = CAUSE_ACC_ERR;
                    end else if (cf_acc_warn != 15'd0 && hm_mag_sq > wsq && lvl == LVL_OK) begin
                        lvl   = LVL_WARN;
                        cause = CAUSE_ACC_WARN;
                    end
                end
            end
            r.health_level   = lvl;
            r.health_cause   = cause;
            r.window_samples = hm_count[8:0];
            r.window_span_us = span[20:0];
            r.since_last_us  = since;
            r.acc_mag_sq     = hm_mag_sq;
            pending_reports.push_back(r);
        end
    endtask

    // send one word, with a random idle gap ahead of it
    task automatic send_word(input t_in_word w);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < idle_pct && gap < 60)
            gap = gap + 1;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        predict_health(w);
    endtask

    // hold input until every report is back, then let the block go quiet
    task automatic drain(input int settle);
        i_in_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        case (idx)
            CFG_EXP_RATE: cf_rate       = val[15:0];
            CFG_WARN_RAT: cf_warn_ratio = val[8:0];
            CFG_ERR_RAT:  cf_err_ratio  = val[8:0];
            CFG_STALE:    cf_stale      = val;
            CFG_ACC_WARN: cf_acc_warn   = val[14:0];
            CFG_ACC_ERR:  cf_acc_err    = val[14:0];
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [31:0] rate, input logic [31:0] warn_r,
                                input logic [31:0] err_r, input logic [31:0] stale,
                                input logic [31:0] acc_w, input logic [31:0] acc_e);
        write_reg(CFG_EXP_RATE, rate);
        write_reg(CFG_WARN_RAT, warn_r);
        write_reg(CFG_ERR_RAT, err_r);
        write_reg(CFG_STALE, stale);
        write_reg(CFG_ACC_WARN, acc_w);
        write_reg(CFG_ACC_ERR, acc_e);
        i_cfg_we <= 1'b0;
    endtask

    function automatic void add_sample(input logic [31:0] t, input logic rb, input logic ab,
                                       input logic [15:0] x, input logic [15:0] y,
                                       input logic [15:0] z);
        t_row row;
        row.word.cmd          = CMD_SAMPLE;
        row.word.time_us      = t;
        row.word.rot_rate_bad = rb;
        row.word.lin_acc_bad  = ab;
        row.word.lin_acc_x    = x;
        row.word.lin_acc_y    = y;
        row.word.lin_acc_z    = z;
        row.typed             = 1'b0;
        row.want              = '0;
        script.push_back(row);
    endfunction

    function automatic void add_check(input logic [31:0] t, input bit typed,
                                      input t_out_word want_word);
        t_row row;
        row.word         = '0;
        row.word.cmd     = CMD_CHECK;
        row.word.time_us = t;
        row.typed        = typed;
        row.want         = want_word;
        script.push_back(row);
    endfunction

    // component value within two of a magnitude limit, either sign
    function automatic logic [15:0] near_limit(input logic [14:0] lim);
        int v;
        v = int'(lim) + int'($urandom_range(0, 4)) - 2;
        if (v > 32767)
            v = 32767;
        if ($urandom_range(0, 1) == 1)
            v = -v;
        return v[15:0];
    endfunction

    // random part: sample streams at periods from half to three times the expected one, with noise
    task automatic run_random(input int count);
        t_in_word w;
        int       base, period, step, kind, ax, ay;
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0) begin
                base = (cf_rate == 16'd0) ? $urandom_range(200, 5000) : 1000000 / cf_rate;
                case ($urandom_range(0, 3))
                    0: period = base;
                    1: period = base * 3 / 2;
                    2: period = base * 3;
                    default: period = base / 2;
                endcase
                if (period < 1)
                    period = 1;
            end
            // one hold-off per phase until every report is back
            if (i == count / 2)
                drain(0);
            w.cmd          = $urandom_range(0, 1);
            w.time_us      = $urandom();
            w.rot_rate_bad = $urandom_range(0, 1);
            w.lin_acc_bad  = $urandom_range(0, 1);
            w.lin_acc_x    = $urandom();
            w.lin_acc_y    = $urandom();
            w.lin_acc_z    = $urandom();
            kind = $urandom_range(0, 99);
            if (kind < 88) begin
                w.cmd = ($urandom_range(0, 4) == 0) ? CMD_CHECK : CMD_SAMPLE;
                if (w.cmd == CMD_SAMPLE) begin
                    step = period + int'($urandom_range(0, period / 8)) - period / 16;
                    if (step < 1)
                        step = 1;
                    stream_now     = stream_now + step;
                    w.time_us      = stream_now;
                    w.rot_rate_bad = ($urandom_range(0, 19) == 0);
                    w.lin_acc_bad  = ($urandom_range(0, 19) == 0);
                    ax = int'($urandom_range(0, 1200)) - 600;
                    ay = int'($urandom_range(0, 1200)) - 600;
                    case ($urandom_range(0, 4))
                        0: begin
                            w.lin_acc_x = '0;
                            w.lin_acc_y = '0;
                            w.lin_acc_z = '0;
                        end
                        1: begin
                            w.lin_acc_x = ax[15:0];
                            w.lin_acc_y = ay[15:0];
                            w.lin_acc_z = 16'(2511 + ax / 2);
                        end
                        2: begin
                            w.lin_acc_x = '0;
                            w.lin_acc_y = '0;
                            w.lin_acc_z = near_limit(cf_acc_warn);
                        end
                        3: begin
                            w.lin_acc_x = '0;
                            w.lin_acc_y = '0;
                            w.lin_acc_z = near_limit(cf_acc_err);
                        end
                        default: ;
                    endcase
                end else begin
                    case ($urandom_range(0, 9))
                        0:       w.time_us = stream_now + cf_stale + $urandom_range(0, 1);
                        1, 2:    w.time_us = stream_now;
                        default: w.time_us = stream_now + $urandom_range(0, period);
                    endcase
                end
            end else if (w.cmd == CMD_SAMPLE) begin
                // irregular arrival, now and then a long jump
                if ($urandom_range(0, 7) == 0)
                    w.time_us = stream_now + $urandom_range(0, 3000000);
                else
                    w.time_us = stream_now + $urandom_range(0, 2 * period);
                stream_now = w.time_us;
            end else if ($urandom_range(0, 1) == 0) begin
                w.time_us = stream_now + $urandom_range(0, 4 * period);
            end
            send_word(w);
        end
    endtask

    // compare each result word with the oldest queued report
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = o_out_word;
            if (pending_reports.size() == 0) begin
                bad_count = bad_count + 1;
                if (bad_count <= MAX_SHOWN)
                    $display("unexpected result word: level %0d cause %0d samples %0d",
                             got.health_level, got.health_cause, got.window_samples);
            end else begin
                want = pending_reports.pop_front();
                if (got.health_level !== want.health_level ||
                    got.health_cause !== want.health_cause ||
                    got.window_samples !== want.window_samples ||
                    got.window_span_us !== want.window_span_us ||
                    got.since_last_us !== want.since_last_us ||
                    got.acc_mag_sq !== want.acc_mag_sq) begin
                    bad_count = bad_count + 1;
                    if (bad_count <= MAX_SHOWN) begin
                        $display("mismatch: want lvl %0d cause %0d n %0d span %0d since %0d mag %0d",
                                 want.health_level, want.health_cause, want.window_samples,
                                 want.window_span_us, want.since_last_us, want.acc_mag_sq);
                        $display("          got  lvl %0d cause %0d n %0d span %0d since %0d mag %0d",
                                 got.health_level, got.health_cause, got.window_samples,
                                 got.window_span_us, got.since_last_us, got.acc_mag_sq);
                    end
                end
            end
        end
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_word   <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_EXP_RATE;
        i_cfg_data  <= '0;
        bad_count     = 0;
        idle_pct      = 0;
        stall_pct     = 0;
        stream_now    = 32'd40000;
        hm_head       = 0;
        hm_count      = 0;
        hm_last_us    = '0;
        hm_mag_sq     = '0;
        hm_seen       = 1'b0;
        hm_rot_bad    = 1'b0;
        hm_acc_bad    = 1'b0;
        cf_rate       = RST_EXP_RATE;
        cf_warn_ratio = RST_WARN_RAT;
        cf_err_ratio  = RST_ERR_RAT;
        cf_stale      = RST_STALE;
        cf_acc_warn   = RST_ACC_WARN;
        cf_acc_err    = RST_ACC_ERR;

        // directed words under reset register values
        add_check(32'd0, 1'b1, '{LVL_STALE, CAUSE_NEVER, 9'd0, 21'd0, 32'd0, 32'd0});
        add_check(32'hFFFF_FFFF, 1'b1,
                  '{LVL_STALE, CAUSE_NEVER, 9'd0, 21'd0, 32'hFFFF_FFFF, 32'd0});
        add_sample(32'd1000, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0);
        // a single held time counts as rate zero
        add_check(32'd1000, 1'b1, '{LVL_ERROR, CAUSE_RATE_ERR, 9'd1, 21'd0, 32'd0, 32'd0});
        add_sample(32'd2000, 1'b1, 1'b0, 16'h8000, 16'h8000, 16'h8000);
        add_check(32'd2000, 1'b1,
                  '{LVL_ERROR, CAUSE_GYRO_BAD, 9'd2, 21'd1000, 32'd0, 32'hC000_0000});
        add_sample(32'd3000, 1'b0, 1'b1, 16'h7FFF, 16'd0, 16'd0);
        add_check(32'd3000, 1'b1,
                  '{LVL_ERROR, CAUSE_ACC_BAD, 9'd3, 21'd2000, 32'd0, 32'd1073676289});
        // one past the stale limit, then exactly at it
        add_check(32'd503001, 1'b1,
                  '{LVL_STALE, CAUSE_TIMEOUT, 9'd3, 21'd2000, 32'd500001, 32'd1073676289});
        add_check(32'd503000, 1'b0, '0);
        add_sample(32'd13000, 1'b0, 1'b0, 16'd0, 16'd0, 16'd2511);
        add_check(32'd13000, 1'b0, '0);
        add_sample(32'd23000, 1'b0, 1'b0, 16'd0, 16'd0, 16'd8000);
        add_check(32'd23000, 1'b0, '0);
        add_sample(32'd33000, 1'b0, 1'b0, 16'd0, 16'd0, -16'sd13000);
        add_check(32'd33000, 1'b0, '0);
        // one microsecond past the window drops every older time
        add_sample(32'd2033001, 1'b0, 1'b0, 16'd255, 16'd255, 16'd255);
        add_check(32'd2033001, 1'b0, '0);
        // time wraps between the next two samples
        add_sample(32'hFFFF_FF00, 1'b0, 1'b0, 16'd1, 16'hFFFF, 16'd0);
        add_sample(32'h0000_2000, 1'b0, 1'b0, 16'd0, 16'd0, 16'd2511);
        add_check(32'h0000_2100, 1'b0, '0);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[k]) begin
            send_word(script[k].word);
            if (script[k].typed)
                pending_reports[pending_reports.size() - 1] = script[k].want;
        end
        drain(SETTLE_CYCLES);

        // random phases, each under its own registers and handshake pressure
        for (int p = 1; p <= 6; p++) begin
            case (p)
                1: begin
                    program_regs(RST_EXP_RATE, RST_WARN_RAT, RST_ERR_RAT, RST_STALE,
                                 RST_ACC_WARN, RST_ACC_ERR);
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                2: begin
                    program_regs(32'd1000, 32'd256, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0);
                    idle_pct  = 64;
                    stall_pct = 0;
                end
                3: begin
                    program_regs(32'd0, 32'd0, 32'd256, 32'd0, 32'd32767, 32'd32767);
                    idle_pct  = 0;
                    stall_pct = 64;
                end
                4: begin
                    // bits above a register's width are dropped
                    program_regs(32'd65535, 32'hFFFF_FFFF, 32'd300, 32'd1000000,
                                 32'd2000, 32'd4000);
                    idle_pct   = 27;
                    stall_pct  = 27;
                    stream_now = 32'hFFFF_FF00;
                end
                5: begin
                    program_regs(32'd200, 32'd179, 32'd102, 32'd50000, 32'd7680, 32'd12800);
                    idle_pct  = 64;
                    stall_pct = 0;
                end
                default: begin
                    program_regs($urandom_range(0, 65535), $urandom_range(0, 511),
                                 $urandom_range(0, 511), $urandom(),
                                 $urandom_range(0, 32767), $urandom_range(0, 32767));
                    idle_pct  = 27;
                    stall_pct = 27;
                end
            endcase
            run_random(PHASE_WORDS);
            drain(SETTLE_CYCLES);
        end

        if (bad_count == 0)
            $display("imu_health_monitor_tb: done, clean");
        else
            $display("imu_health_monitor_tb: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
